>>> rtl/bapd_pkg.sv
// Package for the bit-plane asymmetric dot product core.
// Widths, operation and mode codes, shared types and popcount helpers.
// No dependencies.
package bapd_pkg;

	// Payload widths
	localparam int WORD_W   = 64;
	localparam int PLANE_W  = 2;
	localparam int INDEX_W  = 6;
	localparam int MODE_W   = 2;
	localparam int SUM_W    = 18;

	// Query is four bit planes, weights 1, 2, 4, 8
	localparam int QUERY_PLANES = 4;
	localparam int CNT_W        = 7;   // popcount of one 64-bit word, 0..64
	localparam int WSUM_W       = 10;  // weighted sum of four counts, up to 960
	localparam int ADD_W        = 11;  // weighted sum doubled for document plane 1

	localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

	localparam int DEF_MAX_PLANE_WORDS = 64;

	// Operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_SCORE = 1'b1;

	// Document bits per dimension
	localparam logic [MODE_W-1:0] DOC_MODE_ONE = 2'd1;
	localparam logic [MODE_W-1:0] DOC_MODE_TWO = 2'd2;

	// Document plane codes in two-plane mode
	localparam logic [PLANE_W-1:0] DOC_PLANE_LO = 2'd0;
	localparam logic [PLANE_W-1:0] DOC_PLANE_HI = 2'd1;

	typedef logic [QUERY_PLANES-1:0][WORD_W-1:0] bapd_qword_t;
	typedef logic [QUERY_PLANES-1:0][CNT_W-1:0]  bapd_cnt_t;

	// Control that travels with a scored word down the pipeline
	typedef struct packed {
		logic valid;
		logic contrib;  // word adds to the sum at all
		logic dbl;      // document plane 1 in two-plane mode
		logic last;     // emit the sum after this word
	} bapd_ctl_t;

	function automatic logic [3:0] pop8(input logic [7:0] x);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			n = n + 4'(x[i]);
		end
		return n;
	endfunction

	function automatic logic [CNT_W-1:0] pop64(input logic [WORD_W-1:0] x);
		logic [CNT_W-1:0] n;
		n = '0;
		for (int b = 0; b < 8; b++) begin
			n = n + CNT_W'(pop8(x[b*8 +: 8]));
		end
		return n;
	endfunction

endpackage

>>> rtl/bapd_if.sv
// Request and response channel interfaces of the dot product core.
// Depends on bapd_pkg.
interface bapd_req_if import bapd_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               operation;
	logic [PLANE_W-1:0] plane_select;
	logic [INDEX_W-1:0] word_index;
	logic [WORD_W-1:0]  data_word;
	logic               last_word;

	modport source (
		output valid, operation, plane_select, word_index, data_word, last_word,
		input  ready
	);
	modport sink (
		input  valid, operation, plane_select, word_index, data_word, last_word,
		output ready
	);
endinterface

interface bapd_rsp_if import bapd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] dot_product;

	modport source (output valid, dot_product, input ready);
	modport sink (input valid, dot_product, output ready);
endinterface

>>> rtl/bapd_qstore.sv
// Query plane store: one bank per query plane, one write and one read port.
// Read data is registered and held while the read enable is low. Depends on bapd_pkg.
module bapd_qstore import bapd_pkg::*; #(
	parameter int MAX_PLANE_WORDS = DEF_MAX_PLANE_WORDS,
	parameter int AW = 6
) (
	input  logic               clk,
	input  logic               we,
	input  logic [PLANE_W-1:0] wr_plane,
	input  logic [AW-1:0]      wr_addr,
	input  logic [WORD_W-1:0]  wr_data,
	input  logic               rd_en,
	input  logic [AW-1:0]      rd_addr,
	output bapd_qword_t        rd_data
);

	for (genvar p = 0; p < QUERY_PLANES; p++) begin : g_bank
		logic [WORD_W-1:0] mem [MAX_PLANE_WORDS];
		logic [WORD_W-1:0] rd_q;

		// Bank write and registered read
		always_ff @(posedge clk) begin
			if (we && wr_plane == PLANE_W'(p)) begin
				mem[wr_addr] <= wr_data;
			end
			if (rd_en) begin
				rd_q <= mem[rd_addr];
			end
		end

		assign rd_data[p] = rd_q;
	end

endmodule

>>> rtl/bapd_plane_count.sv
// Second pipeline stage: AND of the document word with each query plane and popcount.
// Depends on bapd_pkg.
module bapd_plane_count import bapd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  bapd_ctl_t         ctl_s1,
	input  logic [WORD_W-1:0] doc_s1,
	input  bapd_qword_t       qry_s1,
	output bapd_ctl_t         ctl_s2,
	output bapd_cnt_t         cnt_s2
);

	bapd_cnt_t cnt_d;

	// Per-plane masked popcount
	always_comb begin
		for (int p = 0; p < QUERY_PLANES; p++) begin
			cnt_d[p] = pop64(qry_s1[p] & doc_s1);
		end
	end

	// Stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// Stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			cnt_s2 <= cnt_d;
		end
	end

endmodule

>>> rtl/bapd_accum.sv
// Final stage: plane weighting, saturating running sum and the result register.
// Depends on bapd_pkg.
module bapd_accum import bapd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  bapd_ctl_t        ctl_s2,
	input  bapd_cnt_t        cnt_s2,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [SUM_W-1:0] out_sum
);

	logic [SUM_W-1:0]  running_q;
	logic              out_valid_q;
	logic [SUM_W-1:0]  out_sum_q;
	logic [WSUM_W-1:0] wsum;
	logic [ADD_W-1:0]  add;
	logic [SUM_W:0]    sum_wide;
	logic [SUM_W-1:0]  sum_sat;

	// Weights 1, 2, 4, 8 per query plane
	assign wsum = WSUM_W'(cnt_s2[0])
		+ WSUM_W'({cnt_s2[1], 1'b0})
		+ WSUM_W'({cnt_s2[2], 2'b0})
		+ WSUM_W'({cnt_s2[3], 3'b0});

	// Document plane 1 counts double; non-contributing words add nothing
	always_comb begin
		add = '0;
		if (ctl_s2.contrib) begin
			add = ctl_s2.dbl ? {wsum, 1'b0} : ADD_W'(wsum);
		end
	end

	// Saturating accumulate
	assign sum_wide = (SUM_W+1)'(running_q) + (SUM_W+1)'(add);
	assign sum_sat  = (sum_wide > (SUM_W+1)'(SUM_MAX)) ? SUM_MAX : sum_wide[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				running_q <= ctl_s2.last ? '0 : sum_sat;
			end
			if (take && ctl_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (take && ctl_s2.last) begin
			out_sum_q <= sum_sat;
		end
	end

	assign out_valid = out_valid_q;
	assign out_sum   = out_sum_q;

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !(take && ctl_s2.last))
		else $error("result register overwritten while pending");

	// The sum restarts after each emitted result
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(take && ctl_s2.last) |=> (running_q == '0))
		else $error("running sum not cleared after emit");

	// Only valid stage items are taken
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ctl_s2.valid)
		else $error("accumulate on empty stage");

endmodule

>>> rtl/bitplane_asymmetric_dot_product_core.sv
// Bit-plane asymmetric dot product core. Query plane loads and document words arrive
// on the request channel, one request per clock when the response side keeps up.
// A load writes the query store in the cycle it is accepted and produces no response.
// A scored word passes three stages: query store read (registered), AND and popcount of
// the four query planes, then weighting and the saturating running sum. The sum is
// offered on the response channel from the result register once the word marked last
// has left the accumulator stage. The accumulator loop is a single register, so the
// sustained rate is one request per cycle; the request channel stalls only when a last
// word reaches the accumulator while the previous result is still waiting in the
// response register. The query store holds MAX_PLANE_WORDS words per plane and is not
// cleared by reset.
module bitplane_asymmetric_dot_product_core import bapd_pkg::*; #(
	parameter int MAX_PLANE_WORDS = DEF_MAX_PLANE_WORDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	bapd_req_if.sink          req,
	bapd_rsp_if.source        rsp
);

	localparam int AW = (MAX_PLANE_WORDS > 1) ? $clog2(MAX_PLANE_WORDS) : 1;

	logic [MODE_W-1:0] doc_bits_mode_q;
	bapd_ctl_t         ctl_s1;
	logic [WORD_W-1:0] doc_s1;
	bapd_qword_t       qry_s1;
	bapd_ctl_t         ctl_s2;
	bapd_cnt_t         cnt_s2;
	logic              take;
	logic              en_s2;
	logic              en_s1;
	logic              in_range;
	logic              load_we;
	logic              score_req;
	logic [AW-1:0]     addr;
	bapd_ctl_t         ctl_d;

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			doc_bits_mode_q <= DOC_MODE_ONE;
		end else if (cfg_we) begin
			doc_bits_mode_q <= cfg_wdata;
		end
	end

	// Flow control: a stage moves when the one after it is empty or moving
	assign take  = ctl_s2.valid && (!ctl_s2.last || !rsp.valid || rsp.ready);
	assign en_s2 = !ctl_s2.valid || take;
	assign en_s1 = !ctl_s1.valid || en_s2;
	assign req.ready = en_s1;

	assign in_range  = 32'(req.word_index) < MAX_PLANE_WORDS;
	assign addr      = AW'(req.word_index);
	assign load_we   = req.valid && en_s1 && (req.operation == OP_LOAD) && in_range;
	assign score_req = req.valid && (req.operation == OP_SCORE);

	// Decode how a scored word contributes
	always_comb begin
		ctl_d.valid   = score_req;
		ctl_d.last    = req.last_word;
		ctl_d.contrib = 1'b0;
		ctl_d.dbl     = 1'b0;
		case (doc_bits_mode_q)
			DOC_MODE_ONE: begin
				ctl_d.contrib = in_range;
			end
			DOC_MODE_TWO: begin
				ctl_d.contrib = in_range &&
					(req.plane_select == DOC_PLANE_LO || req.plane_select == DOC_PLANE_HI);
				ctl_d.dbl = req.plane_select == DOC_PLANE_HI;
			end
			default: begin
				ctl_d.contrib = 1'b0;
			end
		endcase
	end

	bapd_qstore #(
		.MAX_PLANE_WORDS(MAX_PLANE_WORDS),
		.AW(AW)
	) u_qstore (
		.clk     (clk),
		.we      (load_we),
		.wr_plane(req.plane_select),
		.wr_addr (addr),
		.wr_data (req.data_word),
		.rd_en   (en_s1),
		.rd_addr (addr),
		.rd_data (qry_s1)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en_s1) begin
			ctl_s1 <= ctl_d;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (en_s1) begin
			doc_s1 <= req.data_word;
		end
	end

	bapd_plane_count u_plane_count (
		.clk   (clk),
		.arst_n(arst_n),
		.en    (en_s2),
		.ctl_s1(ctl_s1),
		.doc_s1(doc_s1),
		.qry_s1(qry_s1),
		.ctl_s2(ctl_s2),
		.cnt_s2(cnt_s2)
	);

	bapd_accum u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.ctl_s2   (ctl_s2),
		.cnt_s2   (cnt_s2),
		.out_ready(rsp.ready),
		.out_valid(rsp.valid),
		.out_sum  (rsp.dot_product)
	);

	// Backpressure only comes from an occupied first stage
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> ctl_s1.valid)
		else $error("request stalled with empty first stage");

	// Loads never enter the scoring pipeline
	a_load_no_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.operation == OP_LOAD) |=> !ctl_s1.valid)
		else $error("load request entered scoring pipeline");

	// Doubling on a contributing word only happens in two-plane mode
	a_dbl_contrib: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl_s1.valid && ctl_s1.dbl && ctl_s1.contrib) |-> (doc_bits_mode_q == DOC_MODE_TWO))
		else $error("double weight outside two-plane mode");

endmodule

>>> bench/bapd_dot_check.sv
`timescale 1ns / 1ps
// Scoreboard for the bit-plane dot product core: watches the register port and both
// channels, predicts every document's dot product and compares returned sums in order.
// Depends on bapd_pkg and the channel interfaces in rtl/bapd_if.sv.
module bapd_dot_check import bapd_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [MODE_W-1:0] cfg_wdata,
	bapd_req_if               req,
	bapd_rsp_if               rsp,
	output int                fail_count,
	output int                pending_dots,
	output int                dots_checked,
	output int                saturated_dots
);

	localparam int STORE_WORDS  = DEF_MAX_PLANE_WORDS;
	localparam int REPORT_LIMIT = 10;

	// Shadow of the query planes, the open document sum and the mode register
	logic [WORD_W-1:0] query_store [QUERY_PLANES][STORE_WORDS];
	logic [SUM_W-1:0]  partial_dot;
	logic [MODE_W-1:0] doc_mode;
	logic [SUM_W-1:0]  expected_dots [$];

	// Popcounts of doc against the four query planes, weighted 1, 2, 4, 8
	function automatic int weighted_match(input int idx, input logic [WORD_W-1:0] doc);
		int acc;
		acc = 0;
		for (int p = 0; p < QUERY_PLANES; p++) begin
			acc += $countones(query_store[p][idx] & doc) << p;
		end
		return acc;
	endfunction

	task automatic note_mismatch(input string what, input int want, input int got);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] %s: expected dot_product %0d, got %0d", $time, what, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		int add;
		int total;
		logic [SUM_W-1:0] want;
		if (!arst_n) begin
			partial_dot = '0;
			doc_mode = DOC_MODE_ONE;
			expected_dots.delete();
			pending_dots = 0;
			fail_count = 0;
			dots_checked = 0;
			saturated_dots = 0;
		end else begin
			if (cfg_we) begin
				doc_mode = cfg_wdata;
			end

			// Returned sums, checked before this edge's request is predicted
			if (rsp.valid && rsp.ready) begin
				if (expected_dots.size() == 0) begin
					note_mismatch("unexpected result", -1, int'(rsp.dot_product));
				end else begin
					want = expected_dots.pop_front();
					dots_checked++;
					if (rsp.dot_product !== want) begin
						note_mismatch("wrong sum", int'(want), int'(rsp.dot_product));
					end
				end
			end

			// Accepted request: loads update the store, scored words the sum
			if (req.valid && req.ready) begin
				if (req.operation == OP_LOAD) begin
					query_store[req.plane_select][req.word_index] = req.data_word;
				end else begin
					add = 0;
					if (doc_mode == DOC_MODE_ONE) begin
						add = weighted_match(int'(req.word_index), req.data_word);
					end else if (doc_mode == DOC_MODE_TWO) begin
						if (req.plane_select == DOC_PLANE_LO) begin
							add = weighted_match(int'(req.word_index), req.data_word);
						end else if (req.plane_select == DOC_PLANE_HI) begin
							add = 2 * weighted_match(int'(req.word_index), req.data_word);
						end
					end
					total = int'(partial_dot) + add;
					if (total > int'(SUM_MAX)) begin
						total = int'(SUM_MAX);
					end
					if (req.last_word) begin
						expected_dots.push_back(SUM_W'(total));
						if (total == int'(SUM_MAX)) begin
							saturated_dots++;
						end
						partial_dot = '0;
					end else begin
						partial_dot = SUM_W'(total);
					end
				end
			end
			pending_dots = expected_dots.size();
		end
	end

endmodule

>>> bench/bitplane_asymmetric_dot_product_core_test.sv
`timescale 1ns / 1ps
// Top of the dot product core testbench: clock, reset, register writes, request
// stimulus with bursts and gaps, a stalling response sink and the verdict.
// Depends on bapd_pkg, rtl/bapd_if.sv, the core and bench/bapd_dot_check.sv.
module bitplane_asymmetric_dot_product_core_test;
	import bapd_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 1900;
	localparam int PHASE_ITEMS   = 240;
	localparam int DRAIN_CYCLES  = 10;
	localparam int HOLD_CYCLES   = 150;
	localparam int STORE_WORDS   = DEF_MAX_PLANE_WORDS;

	// Mode codes outside the two defined ones; scored words add nothing there
	localparam logic [MODE_W-1:0] DOC_MODE_OFF  = 2'd0;
	localparam logic [MODE_W-1:0] DOC_MODE_RSVD = 2'd3;
	// Document planes that add nothing in two-plane mode
	localparam logic [PLANE_W-1:0] DOC_PLANE_2 = 2'd2;
	localparam logic [PLANE_W-1:0] DOC_PLANE_3 = 2'd3;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [MODE_W-1:0] cfg_wdata;

	bapd_req_if req_ch ();
	bapd_rsp_if rsp_ch ();

	int fail_count;
	int pending_dots;
	int dots_checked;
	int saturated_dots;

	int cycle_count = 0;
	int hold_requests = 0;
	int burst_left = 0;
	int requests_sent = 0;
	int query_loads = 0;
	logic [MODE_W-1:0] cur_mode = DOC_MODE_ONE;

	// Query words whose four planes are all loaded may be scored
	bit plane_loaded [QUERY_PLANES][STORE_WORDS];
	bit word_ready [STORE_WORDS];
	int ready_words [$];

	logic [MODE_W-1:0] phase_modes [8] = '{DOC_MODE_ONE, DOC_MODE_TWO, DOC_MODE_TWO,
		DOC_MODE_OFF, DOC_MODE_ONE, DOC_MODE_RSVD, DOC_MODE_TWO, DOC_MODE_ONE};

	bitplane_asymmetric_dot_product_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	bapd_dot_check score_chk (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.req            (req_ch),
		.rsp            (rsp_ch),
		.fail_count     (fail_count),
		.pending_dots   (pending_dots),
		.dots_checked   (dots_checked),
		.saturated_dots (saturated_dots)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timeout after %0d cycles, %0d sums still pending", cycle_count, pending_dots);
		$display("Test completed with failures");
		$finish;
	end

	// Response sink: stall pattern drawn at random from four styles; long hold-off on request
	initial begin : response_sink
		int hold_left;
		int hold_seen;
		int style;
		hold_left = 0;
		hold_seen = 0;
		style = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_requests != hold_seen) begin
				hold_seen = hold_requests;
				hold_left = HOLD_CYCLES;
			end
			if (cycle_count % 200 == 0) begin
				style = $urandom_range(0, 3);
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				case (style)
					0: rsp_ch.ready <= 1'b1;
					1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
					2: rsp_ch.ready <= ($urandom_range(0, 9) < 2);
					default: rsp_ch.ready <= (cycle_count % 5 != 0);
				endcase
			end
		end
	end

	// One request, sent in bursts with random gaps; returns at its acceptance edge
	task automatic send_request(input logic op, input logic [PLANE_W-1:0] plane,
			input logic [INDEX_W-1:0] idx, input logic [WORD_W-1:0] data, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				req_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.plane_select <= plane;
		req_ch.word_index   <= idx;
		req_ch.data_word    <= data;
		req_ch.last_word    <= last;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		requests_sent++;
	endtask

	task automatic load_query(input int plane, input int idx, input logic [WORD_W-1:0] data,
			input logic last);
		send_request(OP_LOAD, PLANE_W'(plane), INDEX_W'(idx), data, last);
		query_loads++;
		plane_loaded[plane][idx] = 1'b1;
		if (!word_ready[idx] && plane_loaded[0][idx] && plane_loaded[1][idx]
				&& plane_loaded[2][idx] && plane_loaded[3][idx]) begin
			word_ready[idx] = 1'b1;
			ready_words.push_back(idx);
		end
	endtask

	// Stop sending, let every sum come back and the pipeline empty
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_dots != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_doc_mode(input logic [MODE_W-1:0] m);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_mode = m;
	endtask

	function automatic logic [WORD_W-1:0] doc_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return {$urandom, $urandom} & {$urandom, $urandom};
			3: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Random document over loaded query words; plane 0/1 mostly in two-plane mode
	task automatic run_document(input int len);
		int idx;
		logic [PLANE_W-1:0] plane;
		for (int i = 0; i < len; i++) begin
			idx = ready_words[$urandom_range(0, ready_words.size() - 1)];
			if (cur_mode == DOC_MODE_TWO && $urandom_range(0, 9) < 8) begin
				plane = $urandom_range(0, 1) ? DOC_PLANE_HI : DOC_PLANE_LO;
			end else begin
				plane = PLANE_W'($urandom_range(0, 3));
			end
			send_request(OP_SCORE, plane, INDEX_W'(idx), doc_word(), i == len - 1);
		end
	endtask

	// Dense query and document long enough to drive the sum into its ceiling
	task automatic saturating_document();
		int idx;
		int len;
		logic [PLANE_W-1:0] plane;
		idx = $urandom_range(0, STORE_WORDS - 1);
		for (int p = 0; p < QUERY_PLANES; p++) begin
			load_query(p, idx, '1, 1'b0);
		end
		len = (cur_mode == DOC_MODE_TWO) ? 150 : 280;
		for (int i = 0; i < len; i++) begin
			plane = (cur_mode == DOC_MODE_TWO) ? DOC_PLANE_HI : PLANE_W'($urandom_range(0, 3));
			send_request(OP_SCORE, plane, INDEX_W'(idx), '1, i == len - 1);
		end
	endtask

	initial begin : stimulus
		int phase;
		int phase_start;
		int random_start;
		int r;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_wdata           <= DOC_MODE_ONE;
		req_ch.valid        <= 1'b0;
		req_ch.operation    <= OP_LOAD;
		req_ch.plane_select <= '0;
		req_ch.word_index   <= '0;
		req_ch.data_word    <= '0;
		req_ch.last_word    <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: query words 0 and 63, last mark on the final load
		for (int p = 0; p < QUERY_PLANES; p++) begin
			load_query(p, 0, '1, 1'b0);
		end
		load_query(0, STORE_WORDS - 1, {32{2'b01}}, 1'b0);
		load_query(1, STORE_WORDS - 1, '1, 1'b0);
		load_query(2, STORE_WORDS - 1, '0, 1'b0);
		load_query(3, STORE_WORDS - 1, 64'h8000_0000_0000_0001, 1'b1);

		// One-plane mode from reset: full word, empty word, ignored plane select
		send_request(OP_SCORE, DOC_PLANE_LO, INDEX_W'(0), '1, 1'b1);
		send_request(OP_SCORE, DOC_PLANE_LO, INDEX_W'(0), '0, 1'b1);
		send_request(OP_SCORE, DOC_PLANE_3, INDEX_W'(STORE_WORDS - 1), '1, 1'b0);
		send_request(OP_SCORE, DOC_PLANE_2, INDEX_W'(0), 64'h1, 1'b1);
		send_request(OP_SCORE, DOC_PLANE_HI, INDEX_W'(STORE_WORDS - 1),
			64'h8000_0000_0000_0000, 1'b1);

		// Two-plane mode: high plane doubles, planes two and three add nothing
		set_doc_mode(DOC_MODE_TWO);
		send_request(OP_SCORE, DOC_PLANE_LO, INDEX_W'(0), '1, 1'b0);
		send_request(OP_SCORE, DOC_PLANE_HI, INDEX_W'(0), '1, 1'b1);
		send_request(OP_SCORE, DOC_PLANE_2, INDEX_W'(STORE_WORDS - 1), '1, 1'b0);
		send_request(OP_SCORE, DOC_PLANE_3, INDEX_W'(0), '1, 1'b0);
		send_request(OP_SCORE, DOC_PLANE_HI, INDEX_W'(STORE_WORDS - 1), '1, 1'b1);

		// Undefined modes return zero
		set_doc_mode(DOC_MODE_OFF);
		send_request(OP_SCORE, DOC_PLANE_LO, INDEX_W'(0), '1, 1'b0);
		send_request(OP_SCORE, DOC_PLANE_HI, INDEX_W'(0), '1, 1'b1);
		set_doc_mode(DOC_MODE_RSVD);
		send_request(OP_SCORE, DOC_PLANE_LO, INDEX_W'(STORE_WORDS - 1), '1, 1'b1);

		// Random phases, one mode each, register written while idle
		random_start = requests_sent;
		phase = 0;
		while (requests_sent - random_start < RANDOM_ITEMS) begin
			set_doc_mode(phase_modes[phase % 8]);
			phase_start = requests_sent;
			if (phase < 2) begin
				saturating_document();
			end
			if (phase == 2) begin
				// Receiver holds off while single-word documents pile up
				hold_requests <= hold_requests + 1;
				repeat (40) run_document(1);
			end
			while (requests_sent - phase_start < PHASE_ITEMS) begin
				r = $urandom_range(0, 99);
				if (r < 12) begin
					repeat ($urandom_range(1, 4)) begin
						load_query($urandom_range(0, 3), $urandom_range(0, STORE_WORDS - 1),
							{$urandom, $urandom}, $urandom_range(0, 4) == 0);
					end
				end else if (r < 60) begin
					run_document($urandom_range(1, 3));
				end else if (r < 92) begin
					run_document($urandom_range(4, 16));
				end else begin
					run_document($urandom_range(17, 64));
				end
			end
			phase++;
		end

		drain_results();
		$display("Checked %0d dot products (%0d at the ceiling) from %0d requests, %0d of them loads,",
			dots_checked, saturated_dots, requests_sent, query_loads);
		$display("over %0d phases of document modes 0 to 3 with stalls and a long hold-off.",
			phase);
		if (pending_dots != 0) begin
			$display("%0d expected dot products never returned", pending_dots);
		end
		if (fail_count == 0 && pending_dots == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

>>> bitplane_asymmetric_dot_product_core.f
rtl/bapd_pkg.sv
rtl/bapd_if.sv
rtl/bapd_qstore.sv
rtl/bapd_plane_count.sv
rtl/bapd_accum.sv
rtl/bitplane_asymmetric_dot_product_core.sv
bench/bapd_dot_check.sv
bench/bitplane_asymmetric_dot_product_core_test.sv
